// File: rtl/core/pwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear table package
// Shared types, codes and sizes for the breakpoint table lookup block.
// ----------------------------------------------------------------------------
package pwl_pkg;

  // Table size and the widths that follow from it.
  localparam int MAX_POINTS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int ENTRY_W    = 64;

  // Divider sizing: quotient bits kept before the result is capped.
  localparam int DIV_STEPS  = 35;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_WRITE        = 2'd0;
  localparam logic [1:0] STATUS_INTERP       = 2'd1;
  localparam logic [1:0] STATUS_CLAMP_BELOW  = 2'd2;
  localparam logic [1:0] STATUS_CLAMP_ABOVE  = 2'd3;

  // Request transaction.
  typedef struct packed {
    logic               cmd;
    logic [3:0]         point_index;
    logic signed [31:0] key_in;
    logic signed [31:0] value_in;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_RD_LAST,
    ST_CHK_LAST,
    ST_RD_SEG,
    ST_SCAN,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_SUM,
    ST_FINISH
  } state_t;

endpackage

// File: rtl/core/piecewise_linear_table_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear table lookup
// Stores Q16.16 breakpoints and answers lookups by clamping or by linear
// interpolation within the segment that holds the key.
// ----------------------------------------------------------------------------
//  Channel  Signals                     Direction  Content
//  req      req_valid / req_ready / req  in         command, index, key, value
//  rsp      rsp_valid / rsp_ready / rsp  out        result value and status
//  cfg      cfg_we / cfg_wdata           in         points_in_use register
//
// A write goes from the accepting state straight to the finish state, which
// loads the response register. An interpolating lookup reads the first and
// last breakpoints, then scans the segments, reading each breakpoint from the
// table RAM, then does the split 33x17 multiply in a low and a high half and
// the 35-bit quotient one bit per cycle, which a zero-width segment or an
// oversized quotient skips. Clamped lookups end at the first or last check.
// One transaction is in flight at a time; req_ready is high only when idle.
// A held response does not block acceptance, only the final load waits.
// Reset is synchronous and sets points_in_use to 1; the table is not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_table_lookup (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pwl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pwl_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_wdata
);

  pwl_pkg::state_t state, state_next;

  logic [4:0]                  pts;
  logic [pwl_pkg::ADDR_W-1:0]  last_idx;
  logic [pwl_pkg::ADDR_W-1:0]  rd_idx;

  logic                        req_fire;
  logic                        ram_we;
  logic [pwl_pkg::ENTRY_W-1:0] ram_wdata;
  logic [pwl_pkg::ENTRY_W-1:0] ram_rdata;
  logic signed [31:0]          rd_key;
  logic signed [31:0]          rd_val;

  logic signed [31:0] key;
  logic signed [31:0] prev_k;
  logic signed [31:0] prev_v;
  logic signed [31:0] cur_k;
  logic signed [31:0] cur_v;

  logic [32:0] mag_t;
  logic [32:0] mag_dy;
  logic [32:0] mag_dx;
  logic        neg;
  logic [64:0] prod;
  logic [32:0] rem;
  logic [pwl_pkg::DIV_STEPS-1:0] quo;
  logic [pwl_pkg::STEP_W-1:0]    step;

  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  logic        found;
  logic        out_free;
  logic signed [32:0] t_d;
  logic signed [32:0] dy_d;
  logic signed [32:0] dx_d;
  logic [16:0] mul_b;
  logic [49:0] mul_p;
  logic [33:0] rem_sh;
  logic        rem_ge;
  logic [32:0] rem_nx;
  logic [pwl_pkg::DIV_STEPS-1:0] q_cap;
  logic signed [35:0] sum;
  logic signed [31:0] sum_sat;

  // Effective last index: a count of zero acts as one, a count past the table
  // acts as the full table.
  always_comb begin
    if (pts == 5'd0) begin
      last_idx = '0;
    end else if (32'(pts) > pwl_pkg::MAX_POINTS) begin
      last_idx = pwl_pkg::ADDR_W'(pwl_pkg::MAX_POINTS - 1);
    end else begin
      last_idx = pwl_pkg::ADDR_W'(pts - 5'd1);
    end
  end

  // Breakpoint table: key in the upper half, value in the lower half.
  assign ram_wdata = {req.key_in, req.value_in};
  assign rd_key    = ram_rdata[63:32];
  assign rd_val    = ram_rdata[31:0];

  pwl_ram #(
    .WIDTH (pwl_pkg::ENTRY_W),
    .DEPTH (pwl_pkg::MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pwl_pkg::ADDR_W'(req.point_index)),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Segment test for the breakpoint just read; the last segment is the fallback.
  assign found = ((key >= prev_k) && (key < rd_key)) || (rd_idx == last_idx);

  // Differences of the chosen segment, 33 bits signed.
  assign t_d  = 33'(key)   - 33'(prev_k);
  assign dy_d = 33'(cur_v) - 33'(prev_v);
  assign dx_d = 33'(cur_k) - 33'(prev_k);

  // Shared multiplier: low then high half of the value difference.
  assign mul_b = (state == pwl_pkg::ST_MUL_LO) ? mag_dy[16:0] : {1'b0, mag_dy[32:17]};
  assign mul_p = mag_t * mul_b;

  // One restoring division step.
  assign rem_sh = {rem, quo[pwl_pkg::DIV_STEPS-1]};
  assign rem_ge = rem_sh >= {1'b0, mag_dx};
  assign rem_nx = rem_ge ? 33'(rem_sh - {1'b0, mag_dx}) : rem_sh[32:0];

  // Cap the quotient at 2^34, apply the sign and saturate to Q16.16.
  always_comb begin
    q_cap = quo;
    if (quo > {1'b1, 34'd0}) begin
      q_cap = {1'b1, 34'd0};
    end
    if (neg) begin
      sum = 36'(prev_v) - 36'({1'b0, q_cap});
    end else begin
      sum = 36'(prev_v) + 36'({1'b0, q_cap});
    end
    if ((sum[35:31] == 5'b00000) || (sum[35:31] == 5'b11111)) begin
      sum_sat = sum[31:0];
    end else if (sum[35]) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = 32'sh7FFF_FFFF;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      pwl_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.cmd == pwl_pkg::CMD_WRITE) ? pwl_pkg::ST_FINISH
                                                        : pwl_pkg::ST_RD_FIRST;
        end
      end
      pwl_pkg::ST_RD_FIRST:  state_next = pwl_pkg::ST_CHK_FIRST;
      pwl_pkg::ST_CHK_FIRST: begin
        state_next = (key < rd_key) ? pwl_pkg::ST_FINISH : pwl_pkg::ST_RD_LAST;
      end
      pwl_pkg::ST_RD_LAST:   state_next = pwl_pkg::ST_CHK_LAST;
      pwl_pkg::ST_CHK_LAST: begin
        if ((key > rd_key) || (last_idx == '0)) begin
          state_next = pwl_pkg::ST_FINISH;
        end else begin
          state_next = pwl_pkg::ST_RD_SEG;
        end
      end
      pwl_pkg::ST_RD_SEG:    state_next = pwl_pkg::ST_SCAN;
      pwl_pkg::ST_SCAN: begin
        state_next = found ? pwl_pkg::ST_DIFF : pwl_pkg::ST_RD_SEG;
      end
      pwl_pkg::ST_DIFF:      state_next = pwl_pkg::ST_MUL_LO;
      pwl_pkg::ST_MUL_LO:    state_next = pwl_pkg::ST_MUL_HI;
      pwl_pkg::ST_MUL_HI:    state_next = pwl_pkg::ST_DIV_INIT;
      pwl_pkg::ST_DIV_INIT: begin
        if ((mag_dx == '0) || ({3'b0, prod[64:35]} >= mag_dx)) begin
          state_next = pwl_pkg::ST_SUM;
        end else begin
          state_next = pwl_pkg::ST_DIV;
        end
      end
      pwl_pkg::ST_DIV: begin
        if (step == pwl_pkg::STEP_W'(pwl_pkg::DIV_STEPS - 1)) begin
          state_next = pwl_pkg::ST_SUM;
        end
      end
      pwl_pkg::ST_SUM:       state_next = pwl_pkg::ST_FINISH;
      pwl_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = pwl_pkg::ST_IDLE;
        end
      end
      default:               state_next = pwl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_ready = (state == pwl_pkg::ST_IDLE);
    req_fire  = req_ready && req_valid;
    ram_we    = req_fire && (req.cmd == pwl_pkg::CMD_WRITE) &&
                (32'(req.point_index) < pwl_pkg::MAX_POINTS);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pwl_pkg::ST_IDLE;
      pts       <= 5'd1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        pts <= cfg_wdata;
      end
      if ((state == pwl_pkg::ST_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      pwl_pkg::ST_IDLE: begin
        key        <= req.key_in;
        rd_idx     <= '0;
        res_value  <= '0;
        res_status <= pwl_pkg::STATUS_WRITE;
      end
      pwl_pkg::ST_CHK_FIRST: begin
        prev_k     <= rd_key;
        prev_v     <= rd_val;
        rd_idx     <= last_idx;
        res_value  <= rd_val;
        res_status <= pwl_pkg::STATUS_CLAMP_BELOW;
      end
      pwl_pkg::ST_CHK_LAST: begin
        rd_idx <= pwl_pkg::ADDR_W'(1);
        if (key > rd_key) begin
          res_value  <= rd_val;
          res_status <= pwl_pkg::STATUS_CLAMP_ABOVE;
        end else begin
          res_value  <= prev_v;
          res_status <= pwl_pkg::STATUS_INTERP;
        end
      end
      pwl_pkg::ST_SCAN: begin
        if (found) begin
          cur_k <= rd_key;
          cur_v <= rd_val;
        end else begin
          prev_k <= rd_key;
          prev_v <= rd_val;
          rd_idx <= rd_idx + pwl_pkg::ADDR_W'(1);
        end
      end
      pwl_pkg::ST_DIFF: begin
        mag_t  <= t_d[32]  ? 33'(-t_d)  : 33'(t_d);
        mag_dy <= dy_d[32] ? 33'(-dy_d) : 33'(dy_d);
        mag_dx <= dx_d[32] ? 33'(-dx_d) : 33'(dx_d);
        neg    <= t_d[32] ^ dy_d[32] ^ dx_d[32];
      end
      pwl_pkg::ST_MUL_LO: begin
        prod <= {15'd0, mul_p};
      end
      pwl_pkg::ST_MUL_HI: begin
        prod <= prod + {mul_p[47:0], 17'd0};
      end
      pwl_pkg::ST_DIV_INIT: begin
        step <= '0;
        rem  <= {3'b0, prod[64:35]};
        if (mag_dx == '0) begin
          quo <= '0;
        end else if ({3'b0, prod[64:35]} >= mag_dx) begin
          quo <= {1'b1, 34'd0};
        end else begin
          quo <= prod[34:0];
        end
      end
      pwl_pkg::ST_DIV: begin
        rem  <= rem_nx;
        quo  <= {quo[pwl_pkg::DIV_STEPS-2:0], rem_ge};
        step <= step + pwl_pkg::STEP_W'(1);
      end
      pwl_pkg::ST_SUM: begin
        res_value  <= sum_sat;
        res_status <= pwl_pkg::STATUS_INTERP;
      end
      default: begin
      end
    endcase
  end

  // Response register.
  always_ff @(posedge clk) begin
    if ((state == pwl_pkg::ST_FINISH) && out_free) begin
      rsp.result_value <= res_value;
      rsp.status       <= res_status;
    end
  end

endmodule

// File: rtl/core/pwl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pwl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear table checker
// Port-level properties of the lookup block, bound to its top level.
// ----------------------------------------------------------------------------
module pwl_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input pwl_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input pwl_pkg::rsp_t rsp,
  input logic          cfg_we,
  input logic [4:0]    cfg_wdata
);

  // A stalled response holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Only one transaction is in flight: ready drops right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // A write completion always carries a zero value.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == pwl_pkg::STATUS_WRITE) |-> rsp.result_value == 32'sd0)
    else $error("write completion with nonzero value");

  // Reset leaves no response pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind piecewise_linear_table_lookup pwl_checker u_pwl_checker (.*);

// File: tb/sv/piecewise_linear_table_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise-linear table lookup testbench
// Drives breakpoint writes and key lookups through the request channel and
// checks each response against a behavioral copy of the table kept here
// or a hand-written one. A short directed table covers clamping, the
// single-point table, equal and unordered keys and the extremes of every
// field. Random phases follow that reload the table, change the point count
// and look up keys at, between and outside the breakpoints.
// ----------------------------------------------------------------------------
module piecewise_linear_table_lookup_tb;

  localparam int     RAND_ITEMS  = 1830;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     DRAIN_WAIT  = 100;
  localparam int     DIR_ROWS    = 23;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;

  // One row of the directed table: either a point-count write or a
  // transaction, with a hand-written response where one is obvious.
  typedef struct packed {
    logic          is_cfg;
    logic [4:0]    cfg_val;
    logic          has_known;
    pwl_pkg::req_t item;
    pwl_pkg::rsp_t known;
  } dir_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  pwl_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  pwl_pkg::rsp_t rsp;
  logic          cfg_we    = 1'b0;
  logic [4:0]    cfg_wdata = 5'd0;

  // Shadow of the breakpoint table and the point count register.
  logic signed [31:0] tbl_key [pwl_pkg::MAX_POINTS];
  logic signed [31:0] tbl_val [pwl_pkg::MAX_POINTS];
  logic [4:0]         tbl_points = 5'd1;

  pwl_pkg::rsp_t answers_due[$];
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  bit   calm         = 1'b0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_WRITE,  4'd0,  32'h0000_0000, 32'h0001_0000},
      '{32'h0000_0000, pwl_pkg::STATUS_WRITE}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0000_0000, 32'h0000_0000},
      '{32'h0001_0000, pwl_pkg::STATUS_INTERP}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd15, 32'h8000_0000, 32'hFFFF_FFFF},
      '{32'h0001_0000, pwl_pkg::STATUS_CLAMP_BELOW}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd7,  32'h7FFF_FFFF, 32'h8000_0000},
      '{32'h0001_0000, pwl_pkg::STATUS_CLAMP_ABOVE}},
    '{1'b1, 5'd0, 1'b0, '0, '0},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0000_0000, 32'h0000_0000},
      '{32'h0001_0000, pwl_pkg::STATUS_INTERP}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0000_0001, 32'h0000_0000},
      '{32'h0001_0000, pwl_pkg::STATUS_CLAMP_ABOVE}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_WRITE,  4'd1,  32'h0002_0000, 32'h7FFF_FFFF},
      '{32'h0000_0000, pwl_pkg::STATUS_WRITE}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_WRITE,  4'd2,  32'h0003_0000, 32'h8000_0000},
      '{32'h0000_0000, pwl_pkg::STATUS_WRITE}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_WRITE,  4'd3,  32'h0003_0000, 32'h1234_5678},
      '{32'h0000_0000, pwl_pkg::STATUS_WRITE}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_WRITE,  4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'h0000_0000, pwl_pkg::STATUS_WRITE}},
    '{1'b1, 5'd4, 1'b0, '0, '0},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd9,  32'h0001_0000, 32'h5555_5555}, '0},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0002_8000, 32'h0000_0000}, '0},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0003_0000, 32'h0000_0000}, '0},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0003_0001, 32'h0000_0000},
      '{32'h1234_5678, pwl_pkg::STATUS_CLAMP_ABOVE}},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'hFFFF_FFFF, 32'h0000_0000},
      '{32'h0001_0000, pwl_pkg::STATUS_CLAMP_BELOW}},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0002_0000, 32'h0000_0000}, '0},
    '{1'b0, 5'd0, 1'b1, '{pwl_pkg::CMD_WRITE,  4'd2,  32'h0004_0000, 32'h8000_0000},
      '{32'h0000_0000, pwl_pkg::STATUS_WRITE}},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0003_0000, 32'h0000_0000}, '0},
    '{1'b1, 5'd2, 1'b0, '0, '0},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0002_0000, 32'h0000_0000}, '0},
    '{1'b0, 5'd0, 1'b0,
      '{pwl_pkg::CMD_LOOKUP, 4'd0,  32'h0000_FFFF, 32'h0000_0000}, '0}
  };

  piecewise_linear_table_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Number of breakpoints a lookup really uses, after the register is clamped.
  function automatic int unsigned points_live();
    int unsigned cnt;
    cnt = tbl_points;
    if (cnt < 1) cnt = 1;
    if (cnt > pwl_pkg::MAX_POINTS) cnt = pwl_pkg::MAX_POINTS;
    return cnt;
  endfunction

  // Applies one transaction to the shadow table and returns its response.
  function automatic pwl_pkg::rsp_t table_answer(input pwl_pkg::req_t item);
    pwl_pkg::rsp_t ans;
    int unsigned  cnt;
    int unsigned  seg;
    int unsigned  i;
    bit           found;
    bit           neg;
    longint       t;
    longint       dy;
    longint       dx;
    longint       y0;
    longint       r;
    logic [63:0]  mt;
    logic [63:0]  mdy;
    logic [63:0]  mdx;
    logic [63:0]  q;
    logic [127:0] quo;
    ans = '0;
    if (item.cmd == pwl_pkg::CMD_WRITE) begin
      tbl_key[item.point_index] = item.key_in;
      tbl_val[item.point_index] = item.value_in;
      ans.status = pwl_pkg::STATUS_WRITE;
      return ans;
    end
    cnt = points_live();
    if (item.key_in < tbl_key[0]) begin
      ans.result_value = tbl_val[0];
      ans.status       = pwl_pkg::STATUS_CLAMP_BELOW;
      return ans;
    end
    if (item.key_in > tbl_key[cnt - 1]) begin
      ans.result_value = tbl_val[cnt - 1];
      ans.status       = pwl_pkg::STATUS_CLAMP_ABOVE;
      return ans;
    end
    ans.status = pwl_pkg::STATUS_INTERP;
    if (cnt == 1) begin
      ans.result_value = tbl_val[0];
      return ans;
    end

    // First segment holding the key; the last one when none does.
    seg   = cnt - 1;
    found = 1'b0;
    for (i = 1; i < cnt; i++) begin
      if (!found && item.key_in >= tbl_key[i - 1] && item.key_in < tbl_key[i]) begin
        seg   = i;
        found = 1'b1;
      end
    end

    // Exact product over the segment width, truncated and capped at 2^34.
    y0  = tbl_val[seg - 1];
    t   = longint'(item.key_in) - longint'(tbl_key[seg - 1]);
    dy  = longint'(tbl_val[seg]) - y0;
    dx  = longint'(tbl_key[seg]) - longint'(tbl_key[seg - 1]);
    mt  = (t < 0) ? -t : t;
    mdy = (dy < 0) ? -dy : dy;
    mdx = (dx < 0) ? -dx : dx;
    if (mdx == 0) begin
      q = '0;
    end else begin
      quo = 128'(mt) * 128'(mdy) / 128'(mdx);
      q   = (quo > (128'd1 << 34)) ? (64'd1 << 34) : quo[63:0];
    end
    neg = ((t < 0) != (dy < 0)) != (dx < 0);
    r   = neg ? y0 - $signed(q) : y0 + $signed(q);
    if (r > Q_MAX) r = Q_MAX;
    if (r < Q_MIN) r = Q_MIN;
    ans.result_value = r[31:0];
    return ans;
  endfunction

  // Sends one transaction, idling first at random, and queues its expected response.
  task automatic send_item(input pwl_pkg::req_t item, input bit use_known,
                           input pwl_pkg::rsp_t known);
    pwl_pkg::rsp_t ans;
    if (!calm && $urandom_range(99) < 31) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 31) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    ans = table_answer(item);
    answers_due.insert(answers_due.size(), use_known ? known : ans);
  endtask

  // Writes the point count once every outstanding response has come back.
  task automatic write_points(input logic [4:0] n);
    req_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tbl_points  = n;
  endtask

  // Response side stalls at random except during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // Compare each response transaction with the oldest expected one.
  always @(posedge clk) begin
    pwl_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected response: result_value %h status %0d",
               rsp.result_value, rsp.status);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (rsp.result_value !== want.result_value) begin
          $error("result_value: expected %h, got %h", want.result_value,
                 rsp.result_value);
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
      end
    end
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int            row;
    int            sent;
    int            phase;
    int            i;
    int            n_look;
    int unsigned   cnt;
    int            keys_q[$];
    int            base;
    bit            reverse;
    pwl_pkg::req_t item;
    longint        k;
    longint        lo;
    longint        hi;
    logic [63:0]   span;
    logic [4:0]    npts;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (row = 0; row < DIR_ROWS; row++) begin
      if (dir_table[row].is_cfg) begin
        write_points(dir_table[row].cfg_val);
      end else begin
        send_item(dir_table[row].item, dir_table[row].has_known, dir_table[row].known);
      end
    end

    // Random phases: optional point count change, table reload, lookups.
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      calm = (phase >= 10 && phase < 16);

      // Point count, extremes first and out-of-range values included.
      if (phase >= 1 && phase <= 4) begin
        case (phase)
          1:       npts = 5'd16;
          2:       npts = 5'd31;
          3:       npts = 5'd0;
          default: npts = 5'd1;
        endcase
        write_points(npts);
      end else if (phase > 4 && $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       npts = 5'd0;
          1:       npts = 5'd1;
          2, 3:    npts = 5'd16;
          4:       npts = 5'($urandom_range(17, 31));
          default: npts = 5'($urandom_range(2, 16));
        endcase
        write_points(npts);
      end

      // Table content: mostly a fresh sorted table, sometimes scattered noise.
      if (phase == 0 || $urandom_range(9) < 7) begin
        keys_q.delete();
        base = int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000;
        case ($urandom_range(3))
          0: for (i = 0; i < pwl_pkg::MAX_POINTS; i++)
               keys_q.insert(keys_q.size(), int'($urandom()));
          1: for (i = 0; i < pwl_pkg::MAX_POINTS; i++)
               keys_q.insert(keys_q.size(), base + int'($urandom_range(32'h0008_0000)));
          2: for (i = 0; i < pwl_pkg::MAX_POINTS; i++)
               keys_q.insert(keys_q.size(), base + int'($urandom_range(32'h00FF_FFFF)));
          default: for (i = 0; i < pwl_pkg::MAX_POINTS; i++)
               keys_q.insert(keys_q.size(),
                             base + i * int'($urandom_range(1, 32'h0010_0000)));
        endcase
        keys_q.sort();
        reverse = $urandom_range(1);
        for (i = 0; i < pwl_pkg::MAX_POINTS; i++) begin
          item.cmd         = pwl_pkg::CMD_WRITE;
          item.point_index = reverse ? 4'(pwl_pkg::MAX_POINTS - 1 - i) : 4'(i);
          item.key_in      = keys_q[item.point_index];
          item.value_in    = ($urandom_range(3) != 0) ? $urandom() :
                             $urandom_range(32'h0002_0000) - 32'h0001_0000;
          send_item(item, 1'b0, '0);
          sent++;
        end
      end else if ($urandom_range(1) == 0) begin
        for (i = $urandom_range(1, 4); i > 0; i--) begin
          item.cmd         = pwl_pkg::CMD_WRITE;
          item.point_index = 4'($urandom_range(15));
          item.key_in      = $urandom();
          item.value_in    = $urandom();
          send_item(item, 1'b0, '0);
          sent++;
        end
      end

      // Lookups at, between and outside the breakpoints in use.
      n_look = $urandom_range(15, 35);
      for (i = 0; i < n_look; i++) begin
        cnt = points_live();
        lo  = tbl_key[0];
        hi  = tbl_key[cnt - 1];
        case ($urandom_range(9))
          0, 1, 2: k = longint'(tbl_key[$urandom_range(cnt - 1)]) +
                       longint'($urandom_range(2)) - 1;
          3, 4, 5, 6: begin
            if (hi > lo) begin
              span = 64'(hi - lo + 1);
              k    = lo + longint'({$urandom(), $urandom()} % span);
            end else begin
              k = lo;
            end
          end
          7: k = $urandom_range(1) ? lo - longint'($urandom_range(1, 1000)) :
                                     hi + longint'($urandom_range(1, 1000));
          8: k = longint'($urandom());
          default: k = $urandom_range(1) ? 64'h7FFF_FFFF : 64'hFFFF_FFFF_8000_0000;
        endcase
        item.cmd         = pwl_pkg::CMD_LOOKUP;
        item.point_index = 4'($urandom_range(15));
        item.key_in      = k[31:0];
        item.value_in    = $urandom();
        send_item(item, 1'b0, '0);
        sent++;
      end
      phase++;
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // Drain, then give the block time to show any stray response.
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
